// ----- hw/rtl/sit_pkg.sv -----
// Shared types and constants for the SACK interval table.
package sit_pkg;

    // Field widths
    localparam int SEQ_W     = 32;
    localparam int TOTAL_W   = 33;
    localparam int ENTRY_W   = 2 * SEQ_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 136;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_DISCARD = 2'd1,
        FN_QUERY   = 2'd2,
        FN_PEEK    = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_POST,
        ST_MV_RD,
        ST_MV_WR,
        ST_WRITE,
        ST_FIN
    } state_t;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic               overflow;
        logic               empty_res;
        logic [TOTAL_W-1:0] total_bytes;
        logic [SEQ_W-1:0]   removed_bytes;
        logic [SEQ_W-1:0]   front_length;
        logic [SEQ_W-1:0]   front_seq;
        logic               front_valid;
        logic               found;
    } result_t;

endpackage

// ----- hw/rtl/sack_interval_table_unit.sv -----
// Top level of the SACK interval table: sorted block store and its sequencer.
//
// Holds up to MAX_BLOCKS disjoint, non-touching byte ranges in ascending
// order in one RAM and serves one request at a time: insert (union merge),
// discard below a cumulative ack, query of a range, and peek at the front.
// Except for a zero-length insert, every request walks the stored blocks
// through the RAM's single read port, and entries that must move (opening
// a slot or closing a gap) are each read, then written back. The input is
// not ready until the current request has finished; the finished result
// sits in an output register, so the next request is taken while a result
// still waits. No clearing pass follows reset: only the first block_count
// entries are ever read.
module sack_interval_table_unit
    import sit_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // seq[31:0], length[63:32]
    input  logic [1:0]           s_axis_tuser,  // func[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // found[0], front_valid[1], front_seq[33:2], front_length[65:34],
    // removed_bytes[97:66], total_bytes[130:98], empty_res[131],
    // overflow[132], zero pad[135:133]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;

    // Request and working registers
    func_t              func_reg, func_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [TOTAL_W-1:0] e_reg, e_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   ins_i_reg, ins_i_next;
    logic [CNT_W-1:0]   ins_k_reg, ins_k_next;
    logic [SEQ_W-1:0]   first_reg, first_next;
    logic [TOTAL_W-1:0] last_reg, last_next;
    logic [TOTAL_W-1:0] acc_reg, acc_next;
    logic               hit_reg, hit_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   mv_src_reg, mv_src_next;
    logic [CNT_W-1:0]   mv_last_reg, mv_last_next;
    logic [CNT_W-1:0]   mv_delta_reg, mv_delta_next;
    logic               mv_up_reg, mv_up_next;
    result_t            result_reg, result_next;

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Decoded read entry
    logic [SEQ_W-1:0]   rd_start;
    logic [SEQ_W-1:0]   rd_len;
    logic [TOTAL_W-1:0] rd_end;
    logic [TOTAL_W-1:0] ack_ext;
    logic [TOTAL_W-1:0] seq_ext;

    // Insert decision terms
    logic [SEQ_W-1:0]   ins_ns;
    logic [TOTAL_W-1:0] ins_ne;
    logic [TOTAL_W-1:0] ins_span;
    logic [CNT_W-1:0]   ins_j;
    logic [CNT_W-1:0]   mv_dst;

    sit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_sit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ENTRY_W-1:SEQ_W];
    assign rd_len   = ram_rdata[SEQ_W-1:0];
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
    assign seq_ext  = {1'b0, seq_reg};
    assign ack_ext  = seq_ext;

    // Merged range for insert
    always_comb
    begin
        ins_ns = seq_reg;
        ins_ne = e_reg;
        if (ins_k_reg != '0)
        begin
            if (first_reg < seq_reg)
            begin
                ins_ns = first_reg;
            end
            if (last_reg > e_reg)
            begin
                ins_ne = last_reg;
            end
        end
    end

    assign ins_span = ins_ne - {1'b0, ins_ns};
    assign ins_j    = ins_i_reg + ins_k_reg;
    assign mv_dst   = mv_up_reg ? (mv_src_reg + CNT_W'(1)) : (mv_src_reg - mv_delta_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    // Sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        seq_next       = seq_reg;
        e_next         = e_reg;
        ptr_next       = ptr_reg;
        ins_i_next     = ins_i_reg;
        ins_k_next     = ins_k_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        mv_src_next    = mv_src_reg;
        mv_last_next   = mv_last_reg;
        mv_delta_next  = mv_delta_reg;
        mv_up_next     = mv_up_reg;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[IDX_W-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = (state_reg == ST_MV_RD) ? mv_src_reg[IDX_W-1:0]
                                                 : ptr_reg[IDX_W-1:0];

        // Drop the result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = func_t'(s_axis_tuser);
                    seq_next   = s_axis_tdata[SEQ_W-1:0];
                    e_next     = {1'b0, s_axis_tdata[SEQ_W-1:0]}
                               + {1'b0, s_axis_tdata[2*SEQ_W-1:SEQ_W]};
                    ptr_next   = '0;
                    ins_i_next = '0;
                    ins_k_next = '0;
                    acc_next   = '0;
                    hit_next   = 1'b0;
                    ovf_next   = 1'b0;
                    if ((func_t'(s_axis_tuser) == FN_INSERT) &&
                        (s_axis_tdata[2*SEQ_W-1:SEQ_W] == '0))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end

            // Issue the read of the next block, or end the walk
            ST_RD:
            begin
                if (ptr_reg == cnt_reg)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end

            // Judge one block against the request
            ST_EVAL:
            begin
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (rd_end < seq_ext)
                        begin
                            ins_i_next = ins_i_reg + CNT_W'(1);
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = ST_RD;
                        end
                        else if ({1'b0, rd_start} <= e_reg)
                        begin
                            if (ins_k_reg == '0)
                            begin
                                first_next = rd_start;
                            end
                            last_next  = rd_end;
                            ins_k_next = ins_k_reg + CNT_W'(1);
                            acc_next   = acc_reg + {1'b0, rd_len};
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = ST_RD;
                        end
                        else
                        begin
                            state_next = ST_POST;
                        end
                    end
                    FN_DISCARD:
                    begin
                        if (rd_end <= ack_ext)
                        begin
                            acc_next   = acc_reg + {1'b0, rd_len};
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = ST_RD;
                        end
                        else
                        begin
                            // Trim the block that straddles the ack in place
                            if (rd_start < seq_reg)
                            begin
                                acc_next  = acc_reg + {1'b0, seq_reg - rd_start};
                                ram_we    = 1'b1;
                                ram_waddr = ptr_reg[IDX_W-1:0];
                                ram_wdata = {seq_reg, SEQ_W'(rd_end - ack_ext)};
                            end
                            state_next = ST_POST;
                        end
                    end
                    FN_QUERY:
                    begin
                        if ((rd_start <= seq_reg) && (e_reg <= rd_end))
                        begin
                            hit_next = 1'b1;
                        end
                        ptr_next   = ptr_reg + CNT_W'(1);
                        state_next = ST_RD;
                    end
                    default:
                    begin
                        first_next = rd_start;
                        acc_next   = {1'b0, rd_len};
                        state_next = ST_POST;
                    end
                endcase
            end

            // Decide on table changes once the walk is over
            ST_POST:
            begin
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (ins_span[TOTAL_W-1] ||
                            ((ins_k_reg == '0) && (cnt_reg == CNT_W'(MAX_BLOCKS))))
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            first_next = ins_ns;
                            last_next  = ins_span;
                            cnt_next   = cnt_reg - ins_k_reg + CNT_W'(1);
                            state_next = ST_WRITE;
                            if ((ins_k_reg == '0) && (ins_i_reg < cnt_reg))
                            begin
                                // Open a slot: shift upward from the top
                                mv_up_next   = 1'b1;
                                mv_src_next  = cnt_reg - CNT_W'(1);
                                mv_last_next = ins_i_reg;
                                state_next   = ST_MV_RD;
                            end
                            else if ((ins_k_reg > CNT_W'(1)) && (ins_j < cnt_reg))
                            begin
                                // Close the gap left by merged blocks
                                mv_up_next    = 1'b0;
                                mv_src_next   = ins_j;
                                mv_last_next  = cnt_reg - CNT_W'(1);
                                mv_delta_next = ins_k_reg - CNT_W'(1);
                                state_next    = ST_MV_RD;
                            end
                        end
                    end
                    FN_DISCARD:
                    begin
                        cnt_next   = cnt_reg - ptr_reg;
                        total_next = total_reg - acc_reg;
                        state_next = ST_FIN;
                        if ((ptr_reg != '0) && (ptr_reg < cnt_reg))
                        begin
                            mv_up_next    = 1'b0;
                            mv_src_next   = ptr_reg;
                            mv_last_next  = cnt_reg - CNT_W'(1);
                            mv_delta_next = ptr_reg;
                            state_next    = ST_MV_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_MV_RD:
            begin
                state_next = ST_MV_WR;
            end

            // Move one entry, then advance the source
            ST_MV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = mv_dst[IDX_W-1:0];
                ram_wdata = ram_rdata;
                if (mv_src_reg == mv_last_reg)
                begin
                    state_next = (func_reg == FN_INSERT) ? ST_WRITE : ST_FIN;
                end
                else
                begin
                    mv_src_next = mv_up_reg ? (mv_src_reg - CNT_W'(1))
                                            : (mv_src_reg + CNT_W'(1));
                    state_next  = ST_MV_RD;
                end
            end

            // Store the merged block
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ins_i_reg[IDX_W-1:0];
                ram_wdata  = {first_reg, last_reg[SEQ_W-1:0]};
                total_next = total_reg - acc_reg + last_reg;
                state_next = ST_FIN;
            end

            // Hand over the result when the output register is free
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    result_next.pad           = '0;
                    result_next.found         = (func_reg == FN_QUERY) && hit_reg;
                    result_next.front_valid   = (func_reg == FN_PEEK) && (cnt_reg != '0);
                    result_next.front_seq     = '0;
                    result_next.front_length  = '0;
                    if ((func_reg == FN_PEEK) && (cnt_reg != '0))
                    begin
                        result_next.front_seq    = first_reg;
                        result_next.front_length = acc_reg[SEQ_W-1:0];
                    end
                    result_next.removed_bytes = (func_reg == FN_DISCARD) ?
                                                acc_reg[SEQ_W-1:0] : '0;
                    result_next.total_bytes   = total_reg;
                    result_next.empty_res     = (cnt_reg == '0);
                    result_next.overflow      = ovf_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        seq_reg      <= seq_next;
        e_reg        <= e_next;
        ptr_reg      <= ptr_next;
        ins_i_reg    <= ins_i_next;
        ins_k_reg    <= ins_k_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        hit_reg      <= hit_next;
        ovf_reg      <= ovf_next;
        mv_src_reg   <= mv_src_next;
        mv_last_reg  <= mv_last_next;
        mv_delta_reg <= mv_delta_next;
        mv_up_reg    <= mv_up_next;
        result_reg   <= result_next;
    end

endmodule

// ----- hw/rtl/sit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sit_checker.sv -----
// Port-level assertions for the SACK interval table, bound to the top level.
module sit_checker
    import sit_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    result_t res;

    assign res = m_axis_tdata;

    // Busy after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Stored blocks are never empty, so no bytes means no blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.empty_res == (res.total_bytes == '0)))
        else $error("empty flag disagrees with byte total");

    // A front block exists only in a non-empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.front_valid) |->
            (!res.empty_res && (res.front_length != '0)))
        else $error("front block reported on an empty table");

    // Rejection only happens when the table holds blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.overflow) |-> !res.empty_res)
        else $error("overflow reported on an empty table");

endmodule

bind sack_interval_table_unit sit_checker u_sit_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the SACK interval table unit: directed table plus random requests.
module testbench;
    import sit_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 200;

    // Directed row: request fields plus an optional hand-written result
    typedef struct {
        func_t       op;
        logic [31:0] seq;
        logic [31:0] len;
        bit          typed;
        result_t     known;
    } step_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // seq[31:0], length[63:32]
    logic [1:0]           s_axis_tuser  = FN_INSERT;  // func[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // found[0], front_valid[1], front_seq[33:2], front_length[65:34],
    // removed_bytes[97:66], total_bytes[130:98], empty_res[131],
    // overflow[132], zero pad[135:133]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the block table
    logic [31:0] tbl_start [DEPTH];
    logic [31:0] tbl_len   [DEPTH];
    int          tbl_count = 0;

    result_t     pending_results [$];
    int          mismatch_count = 0;
    int          stalled_cycles = 0;
    bit          burst_mode     = 1'b0;
    logic [31:0] win_base;

    sack_interval_table_unit #(
        .MAX_BLOCKS(DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [32:0] block_end(int i);
        return {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
    endfunction

    function automatic int idle_draw();
        return burst_mode ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic result_t outcome(bit found, bit fv, logic [31:0] fseq,
                                        logic [31:0] flen, logic [31:0] removed,
                                        logic [32:0] total, bit empty, bit ovf);
        result_t r;
        r               = '0;
        r.found         = found;
        r.front_valid   = fv;
        r.front_seq     = fseq;
        r.front_length  = flen;
        r.removed_bytes = removed;
        r.total_bytes   = total;
        r.empty_res     = empty;
        r.overflow      = ovf;
        return r;
    endfunction

    // Apply one request to the shadow table and return the result it produces
    function automatic result_t apply_request(func_t op, logic [31:0] seq, logic [31:0] len);
        result_t     r;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] new_lo;
        logic [32:0] new_hi;
        logic [32:0] span_len;
        logic [63:0] removed;
        logic [63:0] sum;
        logic [31:0] ns_arr [DEPTH];
        logic [31:0] nl_arr [DEPTH];
        int          lo_idx;
        int          hi_idx;
        int          merged;
        int          drop;
        int          w;
        int          n;

        r       = '0;
        n       = tbl_count;
        removed = '0;
        case (op)
            FN_INSERT:
            begin
                if (len != 32'd0)
                begin
                    lo     = {1'b0, seq};
                    hi     = lo + {1'b0, len};
                    lo_idx = 0;
                    while (lo_idx < n && block_end(lo_idx) < lo)
                        lo_idx++;
                    hi_idx = lo_idx;
                    while (hi_idx < n && {1'b0, tbl_start[hi_idx]} <= hi)
                        hi_idx++;
                    merged = hi_idx - lo_idx;
                    new_lo = lo;
                    new_hi = hi;
                    if (merged > 0)
                    begin
                        if ({1'b0, tbl_start[lo_idx]} < new_lo)
                            new_lo = {1'b0, tbl_start[lo_idx]};
                        if (block_end(hi_idx - 1) > new_hi)
                            new_hi = block_end(hi_idx - 1);
                    end
                    span_len = new_hi - new_lo;
                    // Reject a merged block too long or one slot too many
                    if (span_len > 33'h0_FFFF_FFFF || n - merged + 1 > DEPTH)
                        r.overflow = 1'b1;
                    else
                    begin
                        w = 0;
                        for (int i = 0; i < lo_idx; i++)
                        begin
                            ns_arr[w] = tbl_start[i];
                            nl_arr[w] = tbl_len[i];
                            w++;
                        end
                        ns_arr[w] = new_lo[31:0];
                        nl_arr[w] = span_len[31:0];
                        w++;
                        for (int i = hi_idx; i < n; i++)
                        begin
                            ns_arr[w] = tbl_start[i];
                            nl_arr[w] = tbl_len[i];
                            w++;
                        end
                        for (int i = 0; i < w; i++)
                        begin
                            tbl_start[i] = ns_arr[i];
                            tbl_len[i]   = nl_arr[i];
                        end
                        tbl_count = w;
                    end
                end
            end
            FN_DISCARD:
            begin
                // Drop whole blocks that end at or below the ack
                drop = 0;
                while (drop < n && block_end(drop) <= {1'b0, seq})
                begin
                    removed = removed + 64'(tbl_len[drop]);
                    drop++;
                end
                for (int i = 0; i < n - drop; i++)
                begin
                    tbl_start[i] = tbl_start[i + drop];
                    tbl_len[i]   = tbl_len[i + drop];
                end
                n         = n - drop;
                tbl_count = n;
                // Trim the front block that straddles the ack
                if (n > 0 && tbl_start[0] < seq)
                begin
                    removed    = removed + 64'(seq - tbl_start[0]);
                    span_len   = block_end(0) - {1'b0, seq};
                    tbl_len[0] = span_len[31:0];
                    tbl_start[0] = seq;
                end
                r.removed_bytes = removed[31:0];
            end
            FN_QUERY:
            begin
                hi = {1'b0, seq} + {1'b0, len};
                for (int i = 0; i < n; i++)
                    if (tbl_start[i] <= seq && hi <= block_end(i))
                        r.found = 1'b1;
            end
            default:
            begin
                if (n > 0)
                begin
                    r.front_valid  = 1'b1;
                    r.front_seq    = tbl_start[0];
                    r.front_length = tbl_len[0];
                end
            end
        endcase

        sum = '0;
        for (int i = 0; i < tbl_count; i++)
            sum = sum + 64'(tbl_len[i]);
        r.total_bytes = sum[32:0];
        r.empty_res   = (tbl_count == 0);
        return r;
    endfunction

    // Drive one request, wait for the handshake, then record its expected result
    task automatic send_request(func_t op, logic [31:0] seq, logic [31:0] len,
                                bit typed, result_t known);
        int      gap;
        result_t predicted;

        gap = idle_draw();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, seq};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_request(op, seq, len);
        pending_results = {pending_results, (typed ? known : predicted)};
    endtask

    task automatic check_field(string name, logic [32:0] want_v, logic [32:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
        end
    endtask

    // Stimulus: reset, directed table, random requests, drain
    initial
    begin : stimulus
        step_row_t   dir_rows [$];
        func_t       op;
        logic [31:0] seq;
        logic [31:0] len;
        logic [31:0] off;
        int          pick;
        int          k;

        win_base = $urandom_range(0, 32'h7000_0000);

        // Empty table, then the extremes of seq and length
        dir_rows = {dir_rows, step_row_t'{FN_PEEK, 32'h0, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 0, 1, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_DISCARD, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 0, 1, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'h0, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 0, 1, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 0, 1, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd1000, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 0, 1, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h0_FFFF_FFFF, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_PEEK, 32'h0, 32'h0, 1'b1,
                   outcome(0, 1, 0, 32'hFFFF_FFFF, 0, 33'h0_FFFF_FFFF, 0, 0)}};
        // Merge would exceed the longest block
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd5, 32'hFFFF_FFFF, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h0_FFFF_FFFF, 0, 1)}};
        // Already covered
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd100, 32'd50, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h0_FFFF_FFFF, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_DISCARD, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0)}};
        // Block past the 32-bit end pushes the total into bit 32
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h0_FFFF_FFFF, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'h0, 32'hFFFF_FFFE, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h1_FFFF_FFFD, 0, 0)}};
        // Zero-length query at a block's end counts as inside
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'hFFFF_FFFE, 32'h0, 1'b1,
                                          outcome(1, 0, 0, 0, 0, 33'h1_FFFF_FFFD, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                          outcome(1, 0, 0, 0, 0, 33'h1_FFFF_FFFD, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_PEEK, 32'h0, 32'h0, 1'b1,
                   outcome(0, 1, 0, 32'hFFFF_FFFE, 0, 33'h1_FFFF_FFFD, 0, 0)}};
        // Ack at the front removes nothing
        dir_rows = {dir_rows, step_row_t'{FN_DISCARD, 32'h0, 32'h0, 1'b1,
                                          outcome(0, 0, 0, 0, 0, 33'h1_FFFF_FFFD, 0, 0)}};
        dir_rows = {dir_rows, step_row_t'{FN_DISCARD, 32'd10, 32'h0, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'hFFFF_FFFE, 32'd1, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_DISCARD, 32'hFFFF_FFFE, 32'h0, 1'b0, '0}};
        // Two blocks bridged by a third insert
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd1000, 32'd100, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd1200, 32'd100, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_INSERT, 32'd1100, 32'd100, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'd1000, 32'd300, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_QUERY, 32'd1299, 32'd2, 1'b0, '0}};
        dir_rows = {dir_rows, step_row_t'{FN_PEEK, 32'h0, 32'h0, 1'b0, '0}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].seq, dir_rows[i].len,
                         dir_rows[i].typed, dir_rows[i].known);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Every third stretch of 64 requests runs with no idling
            burst_mode = ((n / 64) % 3) == 2;
            pick       = $urandom_range(0, 99);
            if (pick < 42)
            begin
                op  = FN_INSERT;
                seq = win_base + $urandom_range(0, 4000);
                if ($urandom_range(0, 15) == 0)
                    len = 32'd0;
                else if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 600);
                else
                    len = $urandom_range(1, 48);
            end
            else if (pick < 54)
            begin
                op  = FN_DISCARD;
                len = $urandom;
                if (tbl_count > 0 && $urandom_range(0, 1) == 1)
                    seq = tbl_start[0] + $urandom_range(0, 200);
                else
                    seq = win_base + $urandom_range(0, 4000);
            end
            else if (pick < 74)
            begin
                op = FN_QUERY;
                if (tbl_count > 0 && $urandom_range(0, 2) != 0)
                begin
                    // Aim inside a held block, sometimes running past its end
                    k   = $urandom_range(0, tbl_count - 1);
                    off = $urandom_range(0, tbl_len[k]);
                    seq = tbl_start[k] + off;
                    len = $urandom_range(0, tbl_len[k] - off + 32'd2);
                end
                else
                begin
                    seq = win_base + $urandom_range(0, 4000);
                    len = $urandom_range(0, 200);
                end
            end
            else if (pick < 86)
            begin
                op  = FN_PEEK;
                seq = $urandom;
                len = $urandom;
            end
            else
            begin
                // Noise over the whole field ranges
                op  = func_t'(2'($urandom_range(0, 3)));
                seq = $urandom;
                len = $urandom;
                if (op == FN_INSERT && seq < 32'h8000_0000)
                    len = len >> $urandom_range(8, 31);
            end
            send_request(op, seq, len, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** sack_interval_table_unit: PASSED **");
        else
            $display("** sack_interval_table_unit: FAILED **");
        $finish;
    end

    // Result side: random stall before each result is taken
    initial
    begin : result_sink
        int stall;

        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = idle_draw();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want_r;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no request outstanding: expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want_r = pending_results.pop_front();
                check_field("found", 33'(want_r.found), 33'(got.found));
                check_field("front_valid", 33'(want_r.front_valid), 33'(got.front_valid));
                check_field("front_seq", 33'(want_r.front_seq), 33'(got.front_seq));
                check_field("front_length", 33'(want_r.front_length), 33'(got.front_length));
                check_field("removed_bytes", 33'(want_r.removed_bytes),
                            33'(got.removed_bytes));
                check_field("total_bytes", want_r.total_bytes, got.total_bytes);
                check_field("empty_res", 33'(want_r.empty_res), 33'(got.empty_res));
                check_field("overflow", 33'(want_r.overflow), 33'(got.overflow));
            end
        end
    end

    // Hang detection: no handshake on either side for too long
    always @(posedge clk)
    begin : hang_watch
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles <= 0;
        else if (stalled_cycles == STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("** sack_interval_table_unit: FAILED **");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

endmodule

// ----- sim.f -----
hw/rtl/sit_pkg.sv
hw/rtl/sit_ram.sv
hw/rtl/sack_interval_table_unit.sv
hw/rtl/sit_checker.sv
test/testbench.sv
